// ===== sv/xkfd_pkg.sv =====
`default_nettype none

package xkfd_pkg;

  // Key store geometry
  localparam int unsigned MAX_KEY = 256;
  localparam int unsigned KEY_AW  = $clog2(MAX_KEY);

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  // Header layout
  localparam logic [3:0] MAGIC_LEN   = 4'd6;
  localparam logic [3:0] VERSION_IDX = 4'd6;
  localparam logic [3:0] MASK_IDX    = 4'd7;
  localparam logic [3:0] LEN_IDX     = 4'd13;
  localparam logic [7:0] VERSION     = 8'd1;

  // Result kinds
  localparam logic [1:0] KIND_CONSUMED = 2'd0;
  localparam logic [1:0] KIND_DATA     = 2'd1;
  localparam logic [1:0] KIND_OTHER    = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_MAGIC   = 3'd1;
  localparam logic [2:0] ERR_VERSION = 3'd2;
  localparam logic [2:0] ERR_KEYLEN  = 3'd3;
  localparam logic [2:0] ERR_TRUNC   = 3'd4;

  // Input request
  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
    logic       final_byte;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [7:0] plain_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       end_of_file;
  } out_item_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic [7:0]        raw_byte;
    logic [1:0]        kind;
    logic [2:0]        error_code;
    logic              end_of_file;
    logic [KEY_AW-1:0] key_addr;
  } q_item_t;

  // Key store write from the front
  typedef struct packed {
    logic              en;
    logic [KEY_AW-1:0] addr;
    logic [7:0]        data;
  } key_wr_t;

endpackage

`default_nettype wire

// ===== sv/xkfd_front.sv =====
`default_nettype none

module xkfd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               byte_valid,
  output logic                    byte_ready,
  input  wire xkfd_pkg::in_item_t byte_item,
  input  wire logic               q_full,
  output logic                    q_push,
  output xkfd_pkg::q_item_t       q_data,
  output xkfd_pkg::key_wr_t       key_wr
);

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_KEY    = 5'b00010,
    PH_DATA   = 5'b00100,
    PH_ERROR  = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  function automatic logic [7:0] magic_at(input logic [3:0] idx);
    logic [7:0] m;
    case (idx)
      4'd0:    m = 8'h54;
      4'd1:    m = 8'h49;
      4'd2:    m = 8'h45;
      4'd3:    m = 8'h4E;
      4'd4:    m = 8'h43;
      default: m = 8'h52;
    endcase
    return m;
  endfunction

  phase_t     phase, phase_next, eff_phase;
  logic [3:0] byte_count, byte_count_next, eff_count;
  logic [7:0] mask_byte, mask_byte_next, eff_mask;
  logic [7:0] key_length, key_length_next, eff_len;
  logic [7:0] prev_raw, prev_raw_next, eff_prev;
  logic [7:0] key_position, key_position_next, eff_pos;
  logic [2:0] error_latch, error_latch_next, eff_err;

  logic       accept;
  logic [7:0] b;
  logic       last;
  logic [2:0] err;
  logic [7:0] len;
  logic [7:0] pos_inc;
  logic [1:0] kind;
  logic [7:0] raw_out;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;
  assign b          = byte_item.in_byte;
  assign last       = byte_item.final_byte;

  // Start of file clears the parser before this byte is classified
  always_comb begin
    if (byte_item.first_byte) begin
      eff_phase = PH_HEADER;
      eff_count = '0;
      eff_mask  = '0;
      eff_len   = '0;
      eff_prev  = '0;
      eff_pos   = '0;
      eff_err   = xkfd_pkg::ERR_OK;
    end else begin
      eff_phase = phase;
      eff_count = byte_count;
      eff_mask  = mask_byte;
      eff_len   = key_length;
      eff_prev  = prev_raw;
      eff_pos   = key_position;
      eff_err   = error_latch;
    end
  end

  // Classify the byte and compute next parser state
  always_comb begin
    phase_next        = eff_phase;
    byte_count_next   = eff_count;
    mask_byte_next    = eff_mask;
    key_length_next   = eff_len;
    prev_raw_next     = eff_prev;
    key_position_next = eff_pos;
    error_latch_next  = eff_err;
    err               = xkfd_pkg::ERR_OK;
    len               = b ^ eff_mask;
    pos_inc           = eff_pos + 8'd1;
    kind              = xkfd_pkg::KIND_CONSUMED;
    raw_out           = '0;
    key_wr.en         = 1'b0;
    key_wr.addr       = eff_pos[xkfd_pkg::KEY_AW-1:0];
    key_wr.data       = b ^ eff_prev;

    unique case (eff_phase)
      PH_HEADER: begin
        if (eff_count < xkfd_pkg::MAGIC_LEN) begin
          if (b != magic_at(eff_count)) err = xkfd_pkg::ERR_MAGIC;
        end else if (eff_count == xkfd_pkg::VERSION_IDX) begin
          if (b != xkfd_pkg::VERSION) err = xkfd_pkg::ERR_VERSION;
        end else if (eff_count == xkfd_pkg::MASK_IDX) begin
          mask_byte_next = b;
        end else if (eff_count == xkfd_pkg::LEN_IDX) begin
          if (len == 8'd0 || 32'(len) > xkfd_pkg::MAX_KEY) begin
            err = xkfd_pkg::ERR_KEYLEN;
          end else begin
            key_length_next   = len;
            key_position_next = '0;
            prev_raw_next     = '0;
            phase_next        = PH_KEY;
          end
        end
        if (eff_count < xkfd_pkg::LEN_IDX) byte_count_next = eff_count + 4'd1;
        if (err == xkfd_pkg::ERR_OK && last) err = xkfd_pkg::ERR_TRUNC;
      end
      PH_KEY: begin
        // Un-chain the key byte and store it
        key_wr.en     = accept;
        prev_raw_next = b;
        if (pos_inc >= eff_len) begin
          key_position_next = '0;
          phase_next        = last ? PH_DONE : PH_DATA;
        end else begin
          key_position_next = pos_inc;
          if (last) err = xkfd_pkg::ERR_TRUNC;
        end
      end
      PH_DATA: begin
        kind              = xkfd_pkg::KIND_DATA;
        raw_out           = b;
        key_position_next = (pos_inc >= eff_len) ? 8'd0 : pos_inc;
        if (last) phase_next = PH_DONE;
      end
      PH_ERROR: begin
        kind = xkfd_pkg::KIND_OTHER;
      end
      PH_DONE: begin
        kind = xkfd_pkg::KIND_OTHER;
      end
      default: begin
        kind = xkfd_pkg::KIND_OTHER;
      end
    endcase

    if (err != xkfd_pkg::ERR_OK) begin
      error_latch_next = err;
      phase_next       = PH_ERROR;
      kind             = xkfd_pkg::KIND_OTHER;
    end
  end

  // Build the request for the back end
  always_comb begin
    q_push              = accept;
    q_data.raw_byte     = raw_out;
    q_data.kind         = kind;
    q_data.end_of_file  = last;
    q_data.key_addr     = eff_pos[xkfd_pkg::KEY_AW-1:0];
    if (eff_phase == PH_ERROR) begin
      q_data.error_code = eff_err;
    end else begin
      q_data.error_code = err;
    end
  end

  // Advance parser state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      byte_count   <= '0;
      mask_byte    <= '0;
      key_length   <= '0;
      prev_raw     <= '0;
      key_position <= '0;
      error_latch  <= xkfd_pkg::ERR_OK;
    end else if (accept) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      mask_byte    <= mask_byte_next;
      key_length   <= key_length_next;
      prev_raw     <= prev_raw_next;
      key_position <= key_position_next;
      error_latch  <= error_latch_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/xkfd_fifo.sv =====
`default_nettype none

module xkfd_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire xkfd_pkg::q_item_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output xkfd_pkg::q_item_t      pop_data,
  output logic                   empty
);

  xkfd_pkg::q_item_t             entries [xkfd_pkg::Q_DEPTH];
  logic [xkfd_pkg::Q_AW-1:0]     wr_ptr;
  logic [xkfd_pkg::Q_AW-1:0]     rd_ptr;
  logic [xkfd_pkg::Q_AW:0]       count;

  assign full     = (count == (xkfd_pkg::Q_AW+1)'(xkfd_pkg::Q_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Hold queued requests
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ===== sv/xkfd_back.sv =====
`default_nettype none

module xkfd_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire xkfd_pkg::key_wr_t  key_wr,
  input  wire logic               q_empty,
  input  wire xkfd_pkg::q_item_t  q_data,
  output logic                    q_pop,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output xkfd_pkg::out_item_t     result_item
);

  logic [7:0]        key_mem [xkfd_pkg::MAX_KEY];
  logic [7:0]        key_rdata;
  xkfd_pkg::q_item_t s1_item;
  logic              s1_valid;
  logic              adv;
  logic              s1_load;
  logic [7:0]        plain;

  assign adv     = !result_valid || result_ready;
  assign s1_load = !s1_valid || adv;
  assign q_pop   = s1_load && !q_empty;

  // Key store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (key_wr.en) key_mem[key_wr.addr] <= key_wr.data;
    if (q_pop) key_rdata <= key_mem[q_data.key_addr];
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_load) s1_valid     <= !q_empty;
      if (adv)     result_valid <= s1_valid;
    end
  end

  // Decode data bytes with the key; all other kinds carry a zero byte
  always_comb begin
    if (s1_item.kind == xkfd_pkg::KIND_DATA) begin
      plain = s1_item.raw_byte ^ key_rdata;
    end else begin
      plain = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) s1_item <= q_data;
    if (adv && s1_valid) begin
      result_item.plain_byte  <= plain;
      result_item.kind        <= s1_item.kind;
      result_item.error_code  <= s1_item.error_code;
      result_item.end_of_file <= s1_item.end_of_file;
    end
  end

endmodule

`default_nettype wire

// ===== sv/xor_key_file_decoder.sv =====
// Channel  | Direction | Handshake                   | Payload
// byte     | in        | byte_valid / byte_ready     | byte_item (in_byte, first_byte, final_byte)
// result   | out       | result_valid / result_ready | result_item (plain_byte, kind, error_code,
//          |           |                             |   end_of_file)
//
// One byte per cycle sustained while the queue is not full; each request passes through the queue write
// at the accepting edge, the key store read and the output register before its result appears.
// The front parser classifies and writes key bytes; a 4-entry queue feeds the back end,
// whose single key store read port sets the one-byte-per-cycle figure.
// byte_ready drops only when the queue is full; result stalls fill the queue first.
// Reset (rst, synchronous) clears parser and pipeline control; the key store needs no clear.
`default_nettype none

module xor_key_file_decoder (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                byte_valid,
  output logic                     byte_ready,
  input  wire xkfd_pkg::in_item_t  byte_item,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output xkfd_pkg::out_item_t      result_item
);

  xkfd_pkg::q_item_t push_data;
  xkfd_pkg::q_item_t pop_data;
  xkfd_pkg::key_wr_t key_wr;
  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;

  xkfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (push_data),
    .key_wr     (key_wr)
  );

  xkfd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  xkfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .key_wr       (key_wr),
    .q_empty      (q_empty),
    .q_data       (pop_data),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule

`default_nettype wire

// ===== sv/xkfd_checker.sv =====
`default_nettype none

module xkfd_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                byte_valid,
  input wire logic                byte_ready,
  input wire xkfd_pkg::in_item_t  byte_item,
  input wire logic                result_valid,
  input wire logic                result_ready,
  input wire xkfd_pkg::out_item_t result_item
);

  // Hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_item))
    else $error("result dropped or changed while stalled");

  // Drop results after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // Non-data results carry a zero byte
  a_plain_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.kind != xkfd_pkg::KIND_DATA |-> result_item.plain_byte == 8'd0)
    else $error("non-data result with nonzero byte");

  // Data and consumed results carry no error
  a_no_err: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_item.kind == xkfd_pkg::KIND_DATA ||
                     result_item.kind == xkfd_pkg::KIND_CONSUMED)
    |-> result_item.error_code == xkfd_pkg::ERR_OK)
    else $error("error code on a good result");

  // Nothing can come out before something went in
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(byte_valid && byte_ready, 3) || $past(result_valid, 1) ||
                            $past(byte_valid, 3) || $past(byte_valid, 4) || !$past(rst, 3))
    else $error("result appeared without a request");

endmodule

bind xor_key_file_decoder xkfd_checker u_xkfd_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_valid   (byte_valid),
  .byte_ready   (byte_ready),
  .byte_item    (byte_item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_item  (result_item)
);

`default_nettype wire
